/* hdl/assert_macros.svh */
// assertion macros for the grain generator rtl
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/ggg_pkg.sv */
// constants, types and sine table for the grain generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ggg_pkg;
    localparam int BUFFER_DEPTH = 16384;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int BUF_LW       = BUF_AW + 1;
    localparam int SINE_Q       = 256;
    localparam int SINE_AW      = $clog2(SINE_Q) + 2;
    localparam int POS_W        = 48;
    localparam int LEN_W        = 17;
    localparam int DIV_NW       = LEN_W + SINE_AW - 1;
    localparam int DIV_DW       = LEN_W;
    localparam int MUL_W        = 32;
    localparam logic [MUL_W-1:0] LEN_MUL   = 32'd441;
    localparam logic [MUL_W-1:0] RECIP_10  = 32'hCCCC_CCCD;
    localparam int               RECIP_SH  = 35;

    typedef enum logic [2:0] {
        CFG_GRAIN_START   = 3'd0,
        CFG_LENGTH_MS     = 3'd1,
        CFG_CARRIER_STEP  = 3'd2,
        CFG_AMPLITUDE     = 3'd3,
        CFG_START_PHASE   = 3'd4,
        CFG_BUFFER_LENGTH = 3'd5,
        CFG_READ_CENTER   = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEN0, ST_LEN1, ST_LEN2, ST_CHECK, ST_WIN_WAIT,
        ST_PH0, ST_PH1, ST_MOD0, ST_MOD1, ST_MEM, ST_MEMD,
        ST_GAIN, ST_GAIN1, ST_PROD, ST_OUT
    } state_t;

    typedef logic [15:0] qtab_t [0:SINE_Q];

    function automatic qtab_t build_qtab();
        qtab_t tab;
        longint unsigned t, u, p, v, q;
        for (int k = 0; k <= SINE_Q; k++)
        begin
            t = (longint'(k) << 30) / SINE_Q;
            u = (t * t) >> 30;
            p = 61;
            p = 3864 - ((p * u) >> 30);
            p = 172273 - ((p * u) >> 30);
            p = 5026990 - ((p * u) >> 30);
            p = 85569306 - ((p * u) >> 30);
            p = 693598669 - ((p * u) >> 30);
            p = 1686629713 - ((p * u) >> 30);
            v = (p * t) >> 30;
            q = (v + 16384) >> 15;
            tab[k] = (q > 32767) ? 16'd32767 : q[15:0];
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    function automatic logic signed [15:0] full_sine(input logic [SINE_AW-1:0] idx);
        logic [1:0]           quad;
        logic [SINE_AW-3:0]   r;
        logic [15:0]          v;
        quad = idx[SINE_AW-1 -: 2];
        r    = idx[SINE_AW-3:0];
        if (quad[0])
            v = QTAB[SINE_Q - int'(r)];
        else
            v = QTAB[r];
        return quad[1] ? -$signed(v) : $signed(v);
    endfunction
endpackage
`default_nettype wire

/* hdl/ggg_if.sv */
// channel interfaces: input word, result word, register write
// uses ggg_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ggg_in_if;
    import ggg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [BUF_AW-1:0]         buffer_index;
    logic signed [15:0]        buffer_value;
    logic [POS_W-1:0]          sample_position;
    modport source (output valid, operation, buffer_index, buffer_value, sample_position,
                    input ready);
    modport sink   (input valid, operation, buffer_index, buffer_value, sample_position,
                    output ready);
endinterface

interface ggg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] grain_sample;
    logic               grain_finished;
    modport source (output valid, grain_sample, grain_finished, input ready);
    modport sink   (input valid, grain_sample, grain_finished, output ready);
endinterface

interface ggg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/ggg_mul.sv */
// shared 32x32 unsigned multiplier with registered product
// uses ggg_pkg
`timescale 1ns / 1ps
`default_nettype none
module ggg_mul (
    input  wire logic                          clk,
    input  wire logic [ggg_pkg::MUL_W-1:0]     a,
    input  wire logic [ggg_pkg::MUL_W-1:0]     b,
    output logic      [2*ggg_pkg::MUL_W-1:0]   p
);
    import ggg_pkg::*;
    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

/* hdl/ggg_div.sv */
// restoring divider, one quotient bit per cycle
// uses ggg_pkg
`timescale 1ns / 1ps
`default_nettype none
module ggg_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ggg_pkg::DIV_NW-1:0]   dividend,
    input  wire logic [ggg_pkg::DIV_DW-1:0]   divisor,
    output logic                              done,
    output logic      [ggg_pkg::DIV_NW-1:0]   quotient,
    output logic      [ggg_pkg::DIV_DW-1:0]   remainder
);
    import ggg_pkg::*;
    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW+1:0] trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_NW-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = trial[DIV_DW+1] ? shifted[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], ~trial[DIV_DW+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

/* hdl/granular_grain_generator.sv */
// granular grain generator top: sequencer, registers, source buffer
// uses ggg_pkg, ggg_if, ggg_mul, ggg_div, assert_macros.svh
//
// channel  dir  word
// in_ch    in   load (operation 0) or tick (operation 1)
// out_ch   out  grain_sample, grain_finished, one per tick
// cfg      in   register index and data, always ready
//
// a load is written to the buffer on acceptance and the sequencer stays idle;
// a tick outside the grain runs the length steps and the check, and inside it
// also runs a shared divider pass (window index), then the phase steps with the
// sine carrier or a second pass (buffer wrap) and a buffer read, then gain steps
// in_ch.ready is high only when the sequencer is idle; a tick also stalls in
// its last state while the output register still holds an unaccepted word
// reset sets control state and config registers to defaults; the buffer is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module granular_grain_generator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ggg_in_if.sink     in_ch,
    ggg_out_if.source  out_ch,
    ggg_cfg_if.sink    cfg
);
    import ggg_pkg::*;

    state_t state_reg, state_next;

    logic [POS_W-1:0]  start_reg;
    logic [10:0]       ms_reg;
    logic [31:0]       step_reg;
    logic [14:0]       amp_reg;
    logic [15:0]       phase_reg;
    logic [14:0]       blen_reg;
    logic [13:0]       center_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W:0]    diff_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [15:0]       win_reg;
    logic signed [15:0] src_reg, src_next;
    logic              src_load;
    logic              sneg_reg;
    logic [BUF_AW-1:0] addr_reg, addr_next;
    logic signed [15:0] res_reg, res_next;
    logic              flag_reg, flag_next;

    logic              out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic              out_flag_reg;
    logic              out_load;

    logic signed [15:0] mem [0:BUFFER_DEPTH-1];
    logic signed [15:0] rd_data_reg;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic               div_start;
    logic [DIV_NW-1:0]  div_n;
    logic [DIV_DW-1:0]  div_d;
    logic               div_done;
    logic [DIV_NW-1:0]  div_q;
    logic [DIV_DW-1:0]  div_r;

    logic [POS_W-1:0]   i_full;
    logic [LEN_W-1:0]   i_s;
    logic [BUF_LW-1:0]  lsat;
    logic signed [LEN_W+1:0] s_val;
    logic [LEN_W-1:0]   s_abs;
    logic [31:0]        phase_sum;
    logic [14:0]        gain;
    logic [15:0]        src_mag;
    logic [30:0]        mag;
    logic [BUF_LW-1:0]  rem_l;
    logic               in_acc, cfg_acc;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    assign i_full  = diff_reg[POS_W-1:0];
    assign i_s     = i_full[LEN_W-1:0];
    assign lsat    = (blen_reg > BUF_LW'(BUFFER_DEPTH)) ? BUF_LW'(BUFFER_DEPTH) : blen_reg;
    assign s_val   = $signed({5'b0, center_reg}) + $signed({2'b0, i_s})
                     - $signed({3'b0, len_reg[LEN_W-1:1]});
    assign s_abs   = s_val[LEN_W+1] ? LEN_W'(-s_val) : s_val[LEN_W-1:0];
    assign phase_sum = {phase_reg, 16'h0000} + mul_p[31:0];
    assign gain    = mul_p[29:15];
    assign src_mag = src_reg[15] ? 16'(-src_reg) : 16'(src_reg);
    assign mag     = mul_p[30:0];
    assign rem_l   = div_r[BUF_LW-1:0];

    ggg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ggg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_n      = '0;
        div_d      = '0;
        flag_next  = flag_reg;
        res_next   = res_reg;
        src_next   = src_reg;
        src_load   = 1'b0;
        addr_next  = addr_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.operation)
                    state_next = ST_LEN0;
            end
            ST_LEN0:
            begin
                mul_a      = MUL_W'(ms_reg);
                mul_b      = LEN_MUL;
                state_next = ST_LEN1;
            end
            ST_LEN1:
            begin
                mul_a      = mul_p[MUL_W-1:0];
                mul_b      = RECIP_10;
                state_next = ST_LEN2;
            end
            ST_LEN2:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                res_next = '0;
                if (diff_reg[POS_W])
                    state_next = ST_OUT;
                else if (i_full >= POS_W'(len_reg))
                begin
                    if (i_full > POS_W'(len_reg))
                        flag_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n      = {i_s, (SINE_AW-1)'(0)};
                    div_d      = len_reg;
                    state_next = ST_WIN_WAIT;
                end
            end
            ST_WIN_WAIT:
            begin
                if (div_done)
                    state_next = (blen_reg == '0) ? ST_PH0 : ST_MOD0;
            end
            ST_PH0:
            begin
                mul_a      = MUL_W'(i_s);
                mul_b      = step_reg;
                state_next = ST_PH1;
            end
            ST_PH1:
            begin
                src_next   = full_sine(phase_sum[31 -: SINE_AW]);
                src_load   = 1'b1;
                state_next = ST_GAIN;
            end
            ST_MOD0:
            begin
                div_start  = 1'b1;
                div_n      = DIV_NW'(s_abs);
                div_d      = DIV_DW'(lsat);
                state_next = ST_MOD1;
            end
            ST_MOD1:
            begin
                if (div_done)
                begin
                    if (sneg_reg && rem_l != '0)
                        addr_next = BUF_AW'(lsat - rem_l);
                    else
                        addr_next = BUF_AW'(rem_l);
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                state_next = ST_MEMD;
            end
            ST_MEMD:
            begin
                src_next   = rd_data_reg;
                src_load   = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                mul_a      = MUL_W'(amp_reg);
                mul_b      = MUL_W'(win_reg);
                state_next = ST_GAIN1;
            end
            ST_GAIN1:
            begin
                mul_a      = MUL_W'(gain);
                mul_b      = MUL_W'(src_mag);
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                if (src_reg[15])
                    res_next = -$signed(16'((32'(mag) + 32'd32767) >> 15));
                else
                    res_next = $signed(16'(mag >> 15));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            ms_reg        <= 11'd50;
            step_reg      <= '0;
            amp_reg       <= 15'd32767;
            phase_reg     <= '0;
            blen_reg      <= '0;
            center_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg_acc)
            begin
                case (cfg.index)
                    CFG_GRAIN_START:   start_reg  <= cfg.data[POS_W-1:0];
                    CFG_LENGTH_MS:     ms_reg     <= cfg.data[10:0];
                    CFG_CARRIER_STEP:  step_reg   <= cfg.data[31:0];
                    CFG_AMPLITUDE:     amp_reg    <= cfg.data[14:0];
                    CFG_START_PHASE:   phase_reg  <= cfg.data[15:0];
                    CFG_BUFFER_LENGTH: blen_reg   <= cfg.data[14:0];
                    CFG_READ_CENTER:   center_reg <= cfg.data[13:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            pos_reg <= in_ch.sample_position;
        if (state_reg == ST_LEN0)
            diff_reg <= {1'b0, pos_reg} - {1'b0, start_reg};
        if (state_reg == ST_LEN2)
            len_reg <= mul_p[RECIP_SH +: LEN_W];
        if (state_reg == ST_WIN_WAIT && div_done)
            win_reg <= 16'(full_sine(div_q[SINE_AW-1:0]));
        if (state_reg == ST_MOD0)
            sneg_reg <= s_val[LEN_W+1];
        if (src_load)
            src_reg <= src_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_sample_reg <= res_reg;
            out_flag_reg   <= flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !in_ch.operation)
            mem[in_ch.buffer_index] <= in_ch.buffer_value;
        rd_data_reg <= mem[addr_reg];
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.grain_sample   = out_sample_reg;
    assign out_ch.grain_finished = out_flag_reg;

    `ASSERT_NEXT(a_flag_sticky, clk, rst_n, flag_reg, flag_reg)
    `ASSERT_NEXT(a_load_one_cycle, clk, rst_n, in_acc && !in_ch.operation, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_out_only_from_out, clk, rst_n, out_load, state_reg == ST_OUT)
endmodule
`default_nettype wire

/* sim/tb.sv */
// testbench for granular_grain_generator: directed and random load/tick words,
// scoreboard class predicts each grain word; uses ggg_pkg and ggg_if
`timescale 1ns / 1ps
module tb;
    import ggg_pkg::*;

    typedef struct {
        bit                 op;
        logic [13:0]        idx;
        logic signed [15:0] val;
        logic [47:0]        pos;
    } grain_word_t;

    typedef struct {
        logic signed [15:0] sample;
        bit                 fin;
    } grain_out_t;

    localparam bit OP_LOAD = 1'b0;
    localparam bit OP_TICK = 1'b1;
    localparam logic [47:0] POS_MASK = 48'hFFFF_FFFF_FFFF;

    class grain_scoreboard;
        logic signed [15:0] src_mem [BUFFER_DEPTH];
        bit                 written [BUFFER_DEPTH];
        bit                 flag;
        logic [47:0]        start;
        logic [10:0]        len_ms;
        logic [31:0]        step;
        logic [14:0]        amp;
        logic [15:0]        phase0;
        logic [14:0]        buf_len;
        logic [13:0]        center;
        logic [15:0]        qtab [0:256];
        grain_out_t         pending [$];
        int                 errors;
        int                 ticks;
        int                 loads;

        function new();
            longint unsigned t, u, p, v, q;
            for (int k = 0; k <= 256; k++)
            begin
                t = (longint'(k) << 30) / 256;
                u = (t * t) >> 30;
                p = 61;
                p = 3864 - ((p * u) >> 30);
                p = 172273 - ((p * u) >> 30);
                p = 5026990 - ((p * u) >> 30);
                p = 85569306 - ((p * u) >> 30);
                p = 693598669 - ((p * u) >> 30);
                p = 1686629713 - ((p * u) >> 30);
                v = (p * t) >> 30;
                q = (v + 16384) >> 15;
                qtab[k] = (q > 32767) ? 16'd32767 : q[15:0];
            end
            flag = 0;
            start = 0;
            len_ms = 50;
            step = 0;
            amp = 32767;
            phase0 = 0;
            buf_len = 0;
            center = 0;
            errors = 0;
            ticks = 0;
            loads = 0;
            for (int k = 0; k < BUFFER_DEPTH; k++)
                written[k] = 0;
        endfunction

        function longint unsigned grain_len();
            return (441 * longint'(len_ms)) / 10;
        endfunction

        function int sine_at(int idx);
            int quad, r, v;
            quad = (idx / 256) & 3;
            r = idx % 256;
            v = (quad & 1) ? qtab[256 - r] : qtab[r];
            return (quad & 2) ? -v : v;
        endfunction

        function void set_reg(cfg_idx_t r, logic [47:0] d);
            case (r)
                CFG_GRAIN_START:   start = d;
                CFG_LENGTH_MS:     len_ms = d[10:0];
                CFG_CARRIER_STEP:  step = d[31:0];
                CFG_AMPLITUDE:     amp = d[14:0];
                CFG_START_PHASE:   phase0 = d[15:0];
                CFG_BUFFER_LENGTH: buf_len = d[14:0];
                CFG_READ_CENTER:   center = d[13:0];
                default: ;
            endcase
        endfunction

        function bit in_grain(logic [47:0] pos);
            return pos >= start && (pos - start) < grain_len();
        endfunction

        function int slot_of(logic [47:0] pos);
            longint s, lim, r;
            lim = (buf_len > BUFFER_DEPTH) ? BUFFER_DEPTH : buf_len;
            s = longint'(center) + longint'(pos - start) - longint'(grain_len() / 2);
            r = s % lim;
            if (r < 0)
                r += lim;
            return int'(r);
        endfunction

        // a tick that would read an entry never loaded
        function bit reads_unloaded(logic [47:0] pos);
            return buf_len != 0 && in_grain(pos) && !written[slot_of(pos)];
        endfunction

        function void note_input(grain_word_t w);
            grain_out_t e;
            longint unsigned i, g;
            longint prod;
            logic [31:0] ph;
            int win, src;
            if (w.op == OP_LOAD)
            begin
                src_mem[w.idx] = w.val;
                written[w.idx] = 1;
                loads++;
                return;
            end
            ticks++;
            e.sample = 0;
            if (w.pos >= start)
            begin
                i = w.pos - start;
                if (i < grain_len())
                begin
                    win = sine_at(int'((i * 512) / grain_len()));
                    if (buf_len == 0)
                    begin
                        ph = ({16'd0, phase0} << 16) + 32'(i * step);
                        src = sine_at(int'(ph >> 22));
                    end
                    else
                        src = src_mem[slot_of(w.pos)];
                    g = (longint'(amp) * longint'(win)) >> 15;
                    prod = longint'(g) * longint'(src);
                    e.sample = 16'(prod >>> 15);
                end
                else if (i > grain_len())
                    flag = 1;
            end
            e.fin = flag;
            pending.insert(pending.size(), e);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [15:0] sample, logic fin);
            grain_out_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word sample %0d", sample));
                return;
            end
            e = pending.pop_front();
            if (sample !== e.sample)
                report($sformatf("grain_sample %0d, want %0d", sample, e.sample));
            if (fin !== e.fin)
                report($sformatf("grain_finished %0b, want %0b", fin, e.fin));
        endtask
    endclass

    logic clk;
    logic rst_n;
    ggg_in_if  in_ch ();
    ggg_out_if out_ch ();
    ggg_cfg_if cfg_ch ();

    granular_grain_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    grain_scoreboard sb = new();
    int hold_cycles = 0;
    int idle_count = 0;
    int phases_run = 0;
    localparam int WATCHDOG_LIMIT = 5000;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // result side
    initial
    begin
        int gap;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0)
            begin
                out_ch.ready = 0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_result(out_ch.grain_sample, out_ch.grain_finished);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task send_word(grain_word_t w, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_ch.operation = w.op;
        in_ch.buffer_index = w.idx;
        in_ch.buffer_value = w.val;
        in_ch.sample_position = w.pos;
        in_ch.valid = 1;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(w);
    endtask

    task stop_sending();
        @(negedge clk);
        in_ch.valid = 0;
    endtask

    task write_reg(cfg_idx_t r, logic [47:0] d);
        @(negedge clk);
        cfg_ch.valid = 1;
        cfg_ch.index = r;
        cfg_ch.data = d;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(r, d);
        @(negedge clk);
        cfg_ch.valid = 0;
    endtask

    task drain();
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task send_tick(logic [47:0] pos, int gap);
        grain_word_t w;
        w.op = OP_TICK;
        w.idx = 14'($urandom);
        w.val = 16'($urandom);
        w.pos = pos & POS_MASK;
        if (sb.reads_unloaded(w.pos))
        begin
            w.op = OP_LOAD;
            w.idx = 14'(sb.slot_of(w.pos));
        end
        send_word(w, gap);
    endtask

    task send_load(logic [13:0] idx, logic signed [15:0] val, int gap);
        grain_word_t w;
        w.op = OP_LOAD;
        w.idx = idx;
        w.val = val;
        w.pos = 48'({$urandom, $urandom});
        send_word(w, gap);
    endtask

    function logic [47:0] pick_pos();
        longint unsigned len;
        len = sb.grain_len();
        case ($urandom_range(0, 9))
            0: return 48'({$urandom, $urandom});
            1: return sb.start - 48'($urandom_range(1, 3));
            2: return 48'(sb.start + len + $urandom_range(0, 3));
            default: return 48'(sb.start + (len == 0 ? 0 : {$urandom, $urandom} % len));
        endcase
    endfunction

    task random_phase(int p, int n);
        logic [47:0] st;
        logic [10:0] lm;
        logic [31:0] stp;
        logic [14:0] am, bl, lim;
        logic [15:0] ph;
        logic [13:0] ctr;
        int gap;
        st  = (p == 0) ? 48'd0 : (p == 1) ? POS_MASK : 48'({$urandom, $urandom});
        lm  = (p == 2) ? 11'd0 : (p == 3) ? 11'd1486 : 11'($urandom_range(1, 20));
        stp = (p == 4) ? 32'h8000_0000 : (p == 5) ? 32'd0 : $urandom_range(0, 32'h8000_0000);
        am  = (p == 6) ? 15'd0 : (p == 7) ? 15'd32767 : 15'($urandom);
        ph  = (p == 4) ? 16'hFFFF : (p == 5) ? 16'd0 : 16'($urandom);
        case (p % 4)
            0: bl = 15'd0;
            1: bl = 15'($urandom_range(1, 64));
            2: bl = (p == 6) ? 15'd32767 : 15'd16384;
            default: bl = 15'($urandom_range(1, 300));
        endcase
        if (p == 1)
            bl = 15'd1;
        ctr = (p == 3) ? 14'd16383 : (p == 5) ? 14'd0 : 14'($urandom);
        write_reg(CFG_GRAIN_START, st);
        write_reg(CFG_LENGTH_MS, 48'(lm));
        write_reg(CFG_CARRIER_STEP, 48'(stp));
        write_reg(CFG_AMPLITUDE, 48'(am));
        write_reg(CFG_START_PHASE, 48'(ph));
        write_reg(CFG_BUFFER_LENGTH, 48'(bl));
        write_reg(CFG_READ_CENTER, 48'(ctr));
        lim = (bl > BUFFER_DEPTH) ? 15'(BUFFER_DEPTH) : bl;
        if (p == 3)
            hold_cycles = 400;
        for (int k = 0; k < n; k++)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            if (p == 5 && k == n / 2)
            begin
                stop_sending();
                while (sb.pending.size() > 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 4) == 0)
                send_load((lim != 0 && $urandom_range(0, 3) != 0) ? 14'($urandom % lim)
                          : 14'($urandom), 16'($urandom), gap);
            else
                send_tick(pick_pos(), gap);
        end
        stop_sending();
        drain();
        phases_run++;
    endtask

    initial
    begin
        in_ch.valid = 0;
        in_ch.operation = OP_LOAD;
        in_ch.buffer_index = 0;
        in_ch.buffer_value = 0;
        in_ch.sample_position = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = CFG_GRAIN_START;
        cfg_ch.data = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset settings, carrier source, grain edges
        send_tick(48'd0, 0);
        send_tick(48'd1, 0);
        send_tick(48'd1102, 1);
        send_tick(48'd2204, 0);
        send_tick(48'd2205, 0);
        send_tick(48'd2206, 2);
        send_tick(48'd1000, 0);
        send_tick(POS_MASK, 0);
        send_load(14'd0, 16'sh7FFF, 0);
        send_load(14'd16383, -16'sh8000, 0);
        send_load(14'd1, 16'sh0, 3);
        stop_sending();
        drain();
        write_reg(CFG_BUFFER_LENGTH, 48'd2);
        write_reg(CFG_LENGTH_MS, 48'd1);
        write_reg(CFG_GRAIN_START, 48'd10);
        write_reg(CFG_READ_CENTER, 48'd16383);
        send_load(14'd1, -16'sh8000, 0);
        for (int k = 8; k < 58; k += 7)
            send_tick(48'(k), 0);
        send_tick(48'd54, 0);
        send_tick(48'd9, 0);
        stop_sending();
        drain();

        for (int p = 0; p < 9; p++)
            random_phase(p, (p == 3) ? 120 : 85);

        $display("covered %0d ticks and %0d loads over %0d register settings",
                 sb.ticks, sb.loads, phases_run + 2);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
